/* src/rbf_pkg.sv */
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared constants and types for the ray / box face hit test.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_X  = 3'd0,
    CFG_MIN_Y  = 3'd1,
    CFG_MIN_Z  = 3'd2,
    CFG_MAX_X  = 3'd3,
    CFG_MAX_Y  = 3'd4,
    CFG_MAX_Z  = 3'd5,
    CFG_MARGIN = 3'd6
  } cfg_idx_t;

endpackage

`default_nettype wire

/* src/rbf_face.sv */
// ----------------------------------------------------------------------------
// rbf_face
// One box face: cross products of the crossing test (multiply stage), then
// sign checks on the sums (decision stage).
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_face #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W:0]   num,
  input  wire logic signed [W:0]   slope,
  input  wire logic signed [W:0]   d_b0,
  input  wire logic signed [W:0]   d_b1,
  input  wire logic signed [W+1:0] elo_b0,
  input  wire logic signed [W+1:0] ehi_b0,
  input  wire logic signed [W+1:0] elo_b1,
  input  wire logic signed [W+1:0] ehi_b1,
  output logic                     hit
);

  localparam int PW = 2*W + 3;

  logic signed [PW-1:0] plo0_r, phi0_r, plo1_r, phi1_r;
  logic signed [PW-2:0] pn0_r, pn1_r;
  logic                 sneg_r, szero_r, nneg_r, nzero_r;
  logic                 hit_r;

  logic signed [PW:0]   tlo0, thi0, tlo1, thi1;
  logic                 dir_ok, ok0, ok1;

  always_ff @(posedge clk) begin
    if (en) begin
      plo0_r  <= elo_b0 * slope;
      phi0_r  <= ehi_b0 * slope;
      plo1_r  <= elo_b1 * slope;
      phi1_r  <= ehi_b1 * slope;
      pn0_r   <= num * d_b0;
      pn1_r   <= num * d_b1;
      sneg_r  <= slope[W];
      szero_r <= (slope == '0);
      nneg_r  <= num[W];
      nzero_r <= (num == '0);
    end
  end

  assign tlo0 = $signed({plo0_r[PW-1], plo0_r}) + $signed({{2{pn0_r[PW-2]}}, pn0_r});
  assign thi0 = $signed({phi0_r[PW-1], phi0_r}) + $signed({{2{pn0_r[PW-2]}}, pn0_r});
  assign tlo1 = $signed({plo1_r[PW-1], plo1_r}) + $signed({{2{pn1_r[PW-2]}}, pn1_r});
  assign thi1 = $signed({phi1_r[PW-1], phi1_r}) + $signed({{2{pn1_r[PW-2]}}, pn1_r});

  assign dir_ok = !szero_r && (nzero_r || (nneg_r == sneg_r));
  assign ok0 = ((tlo0 == '0) || (tlo0[PW] == sneg_r)) &&
               ((thi0 == '0) || (thi0[PW] == !sneg_r));
  assign ok1 = ((tlo1 == '0) || (tlo1[PW] == sneg_r)) &&
               ((thi1 == '0) || (thi1[PW] == !sneg_r));

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= dir_ok && ok0 && ok1;
    end
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

/* src/ray_box_face_hit_test.sv */
// ----------------------------------------------------------------------------
// ray_box_face_hit_test
// Ray versus axis-aligned box test over the six face planes, pipelined.
// ----------------------------------------------------------------------------
// Takes one ray per cycle and returns one hit flag per ray after difference,
// plane offset, multiply, sign decision and output register. Each of the six
// faces has its own multiplier lane, so throughput is one ray per clock
// whenever the output side does not stall; a stall freezes the whole pipeline.
// The user must write box corners and margin through the cfg port while idle; the block does not enforce it.
`default_nettype none

module ray_box_face_hit_test #(
  parameter int COORD_BITS = rbf_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [COORD_BITS-1:0]      in_eye_x,
  input  wire logic signed [COORD_BITS-1:0]      in_eye_y,
  input  wire logic signed [COORD_BITS-1:0]      in_eye_z,
  input  wire logic signed [COORD_BITS-1:0]      in_tip_x,
  input  wire logic signed [COORD_BITS-1:0]      in_tip_y,
  input  wire logic signed [COORD_BITS-1:0]      in_tip_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_hit,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rbf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [COORD_BITS-1:0]             cfg_wdata
);

  import rbf_pkg::*;

  localparam int W = COORD_BITS;

  logic signed [W-1:0] bmin_r [3];
  logic signed [W-1:0] bmax_r [3];
  logic        [W-2:0] margin_r;

  logic                en;
  logic                v1_r, v2_r, v3_r, v4_r, out_valid_r, out_hit_r;

  logic signed [W-1:0] e_in [3];
  logic signed [W-1:0] t_in [3];
  logic signed [W-1:0] e1_r [3];
  logic signed [W:0]   d1_r [3];
  logic signed [W:0]   d2_r [3];
  logic signed [W:0]   lo [3];
  logic signed [W:0]   hi [3];
  logic signed [W+1:0] elo2_r [3];
  logic signed [W+1:0] ehi2_r [3];
  logic signed [W:0]   nmin2_r [3];
  logic signed [W:0]   nmax2_r [3];
  logic        [5:0]   face_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        bmin_r[i] <= '0;
        bmax_r[i] <= '0;
      end
      margin_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_X:  bmin_r[0] <= cfg_wdata;
        CFG_MIN_Y:  bmin_r[1] <= cfg_wdata;
        CFG_MIN_Z:  bmin_r[2] <= cfg_wdata;
        CFG_MAX_X:  bmax_r[0] <= cfg_wdata;
        CFG_MAX_Y:  bmax_r[1] <= cfg_wdata;
        CFG_MAX_Z:  bmax_r[2] <= cfg_wdata;
        CFG_MARGIN: margin_r  <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  assign e_in[0] = in_eye_x;
  assign e_in[1] = in_eye_y;
  assign e_in[2] = in_eye_z;
  assign t_in[0] = in_tip_x;
  assign t_in[1] = in_tip_y;
  assign t_in[2] = in_tip_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo[i] = $signed({bmin_r[i][W-1], bmin_r[i]}) - $signed({2'b00, margin_r});
      hi[i] = $signed({bmax_r[i][W-1], bmax_r[i]}) + $signed({2'b00, margin_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i]    <= e_in[i];
        d1_r[i]    <= $signed({t_in[i][W-1], t_in[i]}) - $signed({e_in[i][W-1], e_in[i]});
        d2_r[i]    <= d1_r[i];
        elo2_r[i]  <= $signed({{2{e1_r[i][W-1]}}, e1_r[i]}) - $signed({lo[i][W], lo[i]});
        ehi2_r[i]  <= $signed({{2{e1_r[i][W-1]}}, e1_r[i]}) - $signed({hi[i][W], hi[i]});
        nmin2_r[i] <= $signed({bmin_r[i][W-1], bmin_r[i]}) - $signed({e1_r[i][W-1], e1_r[i]});
        nmax2_r[i] <= $signed({bmax_r[i][W-1], bmax_r[i]}) - $signed({e1_r[i][W-1], e1_r[i]});
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    localparam int B0 = (a + 1) % 3;
    localparam int B1 = (a + 2) % 3;

    rbf_face #(.W(W)) u_min (
      .clk    (clk),
      .en     (en),
      .num    (nmin2_r[a]),
      .slope  (d2_r[a]),
      .d_b0   (d2_r[B0]),
      .d_b1   (d2_r[B1]),
      .elo_b0 (elo2_r[B0]),
      .ehi_b0 (ehi2_r[B0]),
      .elo_b1 (elo2_r[B1]),
      .ehi_b1 (ehi2_r[B1]),
      .hit    (face_hit[2*a])
    );

    rbf_face #(.W(W)) u_max (
      .clk    (clk),
      .en     (en),
      .num    (nmax2_r[a]),
      .slope  (d2_r[a]),
      .d_b0   (d2_r[B0]),
      .d_b1   (d2_r[B1]),
      .elo_b0 (elo2_r[B0]),
      .ehi_b0 (ehi2_r[B0]),
      .elo_b1 (elo2_r[B1]),
      .ehi_b1 (ehi2_r[B1]),
      .hit    (face_hit[2*a+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= |face_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

`default_nettype wire

/* verif/ray_box_face_hit_test_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_face_hit_test_chk
// Predicts the hit flag of every ray and checks it against the result port.
// ----------------------------------------------------------------------------
// Tracks box corners and margin from cfg writes, computes the exact face-plane
// test with wide signed products for each accepted ray, and compares every
// accepted result with the oldest queued prediction.
module ray_box_face_hit_test_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_tip_x,
  input  logic signed [31:0] in_tip_y,
  input  logic signed [31:0] in_tip_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fails,
  output int                 pending,
  output int                 n_rays,
  output int                 n_hits
);
  import rbf_pkg::*;

  typedef longint vec3_t [3];

  longint box_lo[3];
  longint box_hi[3];
  longint margin_q;
  bit     hit_q[$];

  function automatic int sgn(logic signed [127:0] v);
    return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
  endfunction

  function automatic bit face_crossed(vec3_t e, vec3_t d, int a, longint plane);
    logic signed [127:0] s, num, t;
    longint lo, hi;
    int ss, sn;
    s   = d[a];
    num = plane - e[a];
    ss  = sgn(s);
    sn  = sgn(num);
    if (ss == 0) return 0;
    if (sn != 0 && sn != ss) return 0;
    for (int b = 0; b < 3; b++) begin
      if (b == a) continue;
      lo = box_lo[b] - margin_q;
      hi = box_hi[b] + margin_q;
      t  = 128'(signed'(e[b] - lo)) * s + num * 128'(signed'(d[b]));
      if (sgn(t) != 0 && sgn(t) != ss) return 0;
      t  = 128'(signed'(e[b] - hi)) * s + num * 128'(signed'(d[b]));
      if (sgn(t) != 0 && sgn(t) != -ss) return 0;
    end
    return 1;
  endfunction

  function automatic bit ray_hits(vec3_t e, vec3_t tip);
    vec3_t d;
    for (int a = 0; a < 3; a++) d[a] = tip[a] - e[a];
    for (int a = 0; a < 3; a++)
      if (face_crossed(e, d, a, box_lo[a]) || face_crossed(e, d, a, box_hi[a]))
        return 1;
    return 0;
  endfunction

  assign pending = hit_q.size();

  always @(posedge clk) begin
    vec3_t e, tp;
    bit    want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] = 0;
        box_hi[i] = 0;
      end
      margin_q = 0;
      hit_q.delete();
      fails  <= 0;
      n_rays <= 0;
      n_hits <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_X:  box_lo[0] = longint'(signed'(cfg_wdata));
          CFG_MIN_Y:  box_lo[1] = longint'(signed'(cfg_wdata));
          CFG_MIN_Z:  box_lo[2] = longint'(signed'(cfg_wdata));
          CFG_MAX_X:  box_hi[0] = longint'(signed'(cfg_wdata));
          CFG_MAX_Y:  box_hi[1] = longint'(signed'(cfg_wdata));
          CFG_MAX_Z:  box_hi[2] = longint'(signed'(cfg_wdata));
          CFG_MARGIN: margin_q  = longint'({1'b0, cfg_wdata[30:0]});
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        e  = '{longint'(in_eye_x), longint'(in_eye_y), longint'(in_eye_z)};
        tp = '{longint'(in_tip_x), longint'(in_tip_y), longint'(in_tip_z)};
        hit_q = {hit_q, ray_hits(e, tp)};
      end
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual %0b", $time, out_hit);
          fails <= fails + 1;
        end else begin
          want = hit_q.pop_front();
          if (want !== out_hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, want, out_hit);
            fails <= fails + 1;
          end
          n_rays <= n_rays + 1;
          if (want) n_hits <= n_hits + 1;
        end
      end
    end
  end
endmodule

/* verif/ray_box_face_hit_test_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_face_hit_test_tb
// Stimulus and verdict for the ray / box face hit test.
// ----------------------------------------------------------------------------
// Sweeps several box and margin settings (reset, small, widened, full range,
// inverted, a single point, random), sends directed corner rays and bursts of
// random rays, mostly aimed at or near the box, stalls the result side on a
// changing pattern, and reports ray and hit counts and the checker's verdict.
module ray_box_face_hit_test_tb;
  import rbf_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam longint     MAXC = 64'sd2147483647;
  localparam longint     MINC = -64'sd2147483648;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_eye_x, in_eye_y, in_eye_z;
  logic signed [31:0] in_tip_x, in_tip_y, in_tip_z;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  int                 fails, pending, n_rays, n_hits;

  longint bmin[3], bmax[3];
  int     burst_left;

  ray_box_face_hit_test i_dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_eye_x, .in_eye_y, .in_eye_z, .in_tip_x, .in_tip_y, .in_tip_z,
    .out_valid, .out_stall, .out_hit,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  ray_box_face_hit_test_chk i_chk (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_eye_x, .in_eye_y, .in_eye_z, .in_tip_x, .in_tip_y, .in_tip_z,
    .out_valid, .out_stall, .out_hit,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .fails, .pending, .n_rays, .n_hits
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_ray(longint ex, longint ey, longint ez,
                          longint tx, longint ty, longint tz);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_eye_x <= 32'(ex); in_eye_y <= 32'(ey); in_eye_z <= 32'(ez);
    in_tip_x <= 32'(tx); in_tip_y <= 32'(ty); in_tip_z <= 32'(tz);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_box(longint lx, longint ly, longint lz,
                         longint hx, longint hy, longint hz, longint m);
    drain();
    bmin = '{lx, ly, lz};
    bmax = '{hx, hy, hz};
    cfg_write(CFG_MIN_X, 32'(lx));
    cfg_write(CFG_MIN_Y, 32'(ly));
    cfg_write(CFG_MIN_Z, 32'(lz));
    cfg_write(CFG_MAX_X, 32'(hx));
    cfg_write(CFG_MAX_Y, 32'(hy));
    cfg_write(CFG_MAX_Z, 32'(hz));
    cfg_write(CFG_MARGIN, 32'(m));
  endtask

  function automatic longint rnd32();
    return longint'(signed'(32'($urandom)));
  endfunction

  function automatic longint clamp(longint v);
    return (v > MAXC) ? MAXC : ((v < MINC) ? MINC : v);
  endfunction

  task automatic random_rays(int count);
    longint e[3], t[3], tg, off;
    int     r;
    repeat (count) begin
      r = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        if (r < 2) begin
          e[a] = rnd32();
          t[a] = rnd32();
        end else begin
          tg = (bmax[a] >= bmin[a] && bmax[a] - bmin[a] < 64'sd4000000000) ?
               bmin[a] + longint'($urandom) % (bmax[a] - bmin[a] + 1) : bmin[a];
          off  = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
          e[a] = clamp(tg + off);
          t[a] = (r < 6) ? clamp(tg + longint'($urandom_range(0, 255)) - 128)
                         : clamp(e[a] + (tg - e[a]) / 4);
          if ($urandom_range(0, 7) == 0) t[a] = e[a];
        end
      end
      send_ray(e[0], e[1], e[2], t[0], t[1], t[2]);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_eye_x  = '0; in_eye_y = '0; in_eye_z = '0;
    in_tip_x  = '0; in_tip_y = '0; in_tip_z = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_X;
    cfg_wdata = '0;
    burst_left = 0;
    bmin = '{0, 0, 0};
    bmax = '{0, 0, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset box: a point at the origin
    send_ray(-65536, 0, 0, 65536, 0, 0);
    send_ray(-65536, 1, 0, 65536, 1, 0);
    random_rays(20);

    set_box(-655360, -655360, -655360, 655360, 655360, 655360, 0);
    cfg_write(CFG_UNUSED, 32'hffff_ffff);
    send_ray(-1310720, 0, 0, 1310720, 0, 0);
    send_ray(1310720, 0, 0, 2621440, 0, 0);
    send_ray(-655360, 0, 0, -655360, 65536, 0);
    send_ray(-655360, 655360, 655360, 0, 655360, 655360);
    send_ray(-1310720, 655361, 0, 0, 655361, 0);
    send_ray(5, 5, 5, 5, 5, 5);
    send_ray(-1310720, -1310720, -1310720, 1310720, 1310720, 1310720);
    send_ray(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    send_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_ray(MAXC, 0, 0, MINC, 0, 0);
    send_ray(0, MINC, 0, 0, MAXC, 0);
    send_ray(0, 0, MAXC, 0, 0, MAXC - 1);
    send_ray(-1, -1, -1, 0, 0, 0);
    random_rays(200);

    set_box(-65536, -131072, -196608, 65536, 131072, 196608, 32768);
    send_ray(-1310720, 65536 + 32768, 0, 0, 65536 + 32768, 0);
    send_ray(-1310720, 131072 + 32769, 0, 0, 131072 + 32769, 0);
    random_rays(200);

    set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC, 32'h7fff_ffff);
    send_ray(MINC, MAXC, MINC, MAXC, MINC, MAXC);
    random_rays(200);

    set_box(655360, 655360, 655360, -655360, -655360, -655360, 1024);
    random_rays(200);

    set_box(MAXC, 0, MINC, MAXC, 0, MINC, 0);
    random_rays(100);

    begin
      longint lo[3], hi[3];
      for (int a = 0; a < 3; a++) begin
        lo[a] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        hi[a] = lo[a] + longint'($urandom_range(0, 1 << 21));
      end
      set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 1 << 16));
    end
    random_rays(300);

    drain();
    $display("checked %0d rays over 7 box settings, %0d hits", n_rays, n_hits);
    if (fails == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

/* filelist.f */
src/rbf_pkg.sv
src/rbf_face.sv
src/ray_box_face_hit_test.sv
verif/ray_box_face_hit_test_chk.sv
verif/ray_box_face_hit_test_tb.sv
